[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/lrk_pkg.sv]
// ----------------------------------------------------------------------------
// lrk_pkg
// shared widths, types and fixed-point helpers for the lorenz-96 rk2 stepper
// ----------------------------------------------------------------------------
package lrk_pkg;

  localparam int DIMENSION             = 5;
  localparam int WORD_W                = 32;
  localparam int STEP_W                = 17;
  localparam int FRACTION_BITS_DEFAULT = 16;
  localparam int FIELD_STAGES          = 4;
  // field, scale, midpoint, field, scale, final add
  localparam int PIPE_DEPTH            = 2 * FIELD_STAGES + 4;
  localparam int WIDE_W                = 66;
  localparam int PROD_W                = 2 * WORD_W;
  localparam int SCALED_W              = STEP_W + 1 + WORD_W;

  localparam logic [STEP_W-1:0] STEP_SIZE_RESET = STEP_W'(655);

  typedef logic signed [WORD_W-1:0]   word_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SCALED_W-1:0] scaled_t;
  typedef word_t [DIMENSION-1:0]      vec_t;

  function automatic wide_t widen(input word_t v);
    return wide_t'(v);
  endfunction

  // clamp a wide signed value to the word range
  function automatic word_t sat_word(input wide_t v);
    wide_t hi;
    wide_t lo;
    word_t res;
    hi = {{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    lo = {{(WIDE_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
    if (v > hi) begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (v < lo) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = v[WORD_W-1:0];
    end
    return res;
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic wide_t round_shift(input wide_t v, input int unsigned s);
    wide_t half;
    half = wide_t'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

endpackage

[rtl/lorenz96_rk2_step.sv]
// ----------------------------------------------------------------------------
// lorenz96_rk2_step: one midpoint rk2 step of a five-variable lorenz-96 system
// throughput one beat a cycle while no result beat is held
// rate is set by the 12-stage pipeline, which freezes only on a held result beat
// rst (synchronous) empties the pipeline and sets the dt register to 655 (about 0.01)
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lorenz96_rk2_step #(
  parameter int FRACTION_BITS = lrk_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // input item channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  lrk_pkg::word_t              state_0,
  input  lrk_pkg::word_t              state_1,
  input  lrk_pkg::word_t              state_2,
  input  lrk_pkg::word_t              state_3,
  input  lrk_pkg::word_t              state_4,
  input  lrk_pkg::word_t              forcing,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output lrk_pkg::word_t              next_0,
  output lrk_pkg::word_t              next_1,
  output lrk_pkg::word_t              next_2,
  output lrk_pkg::word_t              next_3,
  output lrk_pkg::word_t              next_4,
  // step size write channel, unsigned fixed point with one integer bit
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lrk_pkg::STEP_W-1:0]  step_size
);
  import lrk_pkg::*;

  // stage map (register stage numbers, counted from the input beat):
  //   1..4   k1 = f(x) in the first field unit
  //   5      m = dt * k1
  //   6      xm = sat(x + rnd(m, fb+1))
  //   7..10  k2 = f(xm) in the second field unit, forcing carried along
  //   11     m = dt * k2
  //   12     next = sat(x + rnd(m, fb)), held in the output register
  localparam int MID_STAGE = FIELD_STAGES + 2;
  localparam int X_TAPS    = PIPE_DEPTH - 1;

  // step size register; written only while the pipeline is empty
  logic [STEP_W-1:0] dt;

  // one valid bit per stage, travelling with the data
  logic [PIPE_DEPTH:1] vld;
  logic                pipe_en;

  vec_t    x_in;
  vec_t    xd [1:X_TAPS];     // input state delayed by 1..X_TAPS beats
  word_t   fd [1:MID_STAGE];  // forcing delayed to the second field unit
  vec_t    k1, k2;
  scaled_t m5  [DIMENSION];
  scaled_t m11 [DIMENSION];
  vec_t    xm6;
  vec_t    res;

  // whole pipeline advances unless a finished beat is held at the output
  assign pipe_en    = !(vld[PIPE_DEPTH] && result_stall);
  assign item_stall = rst || (vld[PIPE_DEPTH] && result_stall);
  // step size only taken with nothing in flight and no input beat offered
  assign cfg_ready  = !rst && (vld == '0) && !item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dt <= STEP_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dt <= step_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (pipe_en) begin
      vld <= {vld[PIPE_DEPTH-1:1], item_valid};
    end
  end

  always_comb begin
    x_in[0] = state_0;
    x_in[1] = state_1;
    x_in[2] = state_2;
    x_in[3] = state_3;
    x_in[4] = state_4;
  end

  // delay lines for the original state and the forcing term
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      xd[1] <= x_in;
      for (int j = 2; j <= X_TAPS; j++) begin
        xd[j] <= xd[j-1];
      end
      fd[1] <= forcing;
      for (int j = 2; j <= MID_STAGE; j++) begin
        fd[j] <= fd[j-1];
      end
    end
  end

  // first field evaluation, k1 = f(x)
  lrk_field #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_field_k1 (
    .clk     (clk),
    .en      (pipe_en),
    .x       (x_in),
    .forcing (forcing),
    .k       (k1)
  );

  // scale by dt, then form the midpoint with the half step folded into the shift
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < DIMENSION; i++) begin
        m5[i]  <= scaled_t'($signed({1'b0, dt})) * scaled_t'(k1[i]);
        xm6[i] <= sat_word(widen(xd[MID_STAGE-1][i])
                           + round_shift(wide_t'(m5[i]), FRACTION_BITS + 1));
      end
    end
  end

  // second field evaluation, k2 = f(xm), forcing unchanged at the midpoint
  lrk_field #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_field_k2 (
    .clk     (clk),
    .en      (pipe_en),
    .x       (xm6),
    .forcing (fd[MID_STAGE]),
    .k       (k2)
  );

  // full step from the original state
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < DIMENSION; i++) begin
        m11[i] <= scaled_t'($signed({1'b0, dt})) * scaled_t'(k2[i]);
        res[i] <= sat_word(widen(xd[X_TAPS][i])
                           + round_shift(wide_t'(m11[i]), FRACTION_BITS));
      end
    end
  end

  assign result_valid = vld[PIPE_DEPTH];
  assign next_0       = res[0];
  assign next_1       = res[1];
  assign next_2       = res[2];
  assign next_3       = res[3];
  assign next_4       = res[4];

  // a held result beat freezes every stage
  `ASSERT_CLK(a_freeze_on_hold, (result_valid && result_stall) |=> $stable(vld),
              "pipeline moved while the result beat was held")
  // a beat in the next-to-last stage reaches the output when the pipe moves
  `ASSERT_CLK(a_last_stage_moves, (pipe_en && vld[PIPE_DEPTH-1]) |=> result_valid,
              "beat lost between the last two stages")
  // nothing comes out in the cycle right after reset
  `ASSERT_NEVER(a_empty_after_reset, $past(rst) && result_valid,
                "result beat present right after reset")

endmodule

[rtl/lrk_field.sv]
// ----------------------------------------------------------------------------
// lrk_field
// four-stage pipelined lorenz-96 vector field: k_i = x[i-1](x[i+1]-x[i-2]) - x[i] + f
// ----------------------------------------------------------------------------
module lrk_field #(
  parameter int FRACTION_BITS = lrk_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          en,
  input  lrk_pkg::vec_t x,
  input  lrk_pkg::word_t forcing,
  output lrk_pkg::vec_t k
);
  import lrk_pkg::*;

  vec_t  x1, x2, x3;
  word_t f1, f2, f3;
  vec_t  d1;
  prod_t prod2 [DIMENSION];
  vec_t  p3;

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x;
      f1 <= forcing;
      x2 <= x1;
      f2 <= f1;
      x3 <= x2;
      f3 <= f2;
    end
  end

  for (genvar i = 0; i < DIMENSION; i++) begin : g_lane
    localparam int NXT = (i + 1) % DIMENSION;
    localparam int PRV = (i + DIMENSION - 1) % DIMENSION;
    localparam int BK2 = (i + DIMENSION - 2) % DIMENSION;

    always_ff @(posedge clk) begin
      if (en) begin
        // difference, product, rounding, combine
        d1[i]    <= sat_word(widen(x[NXT]) - widen(x[BK2]));
        prod2[i] <= prod_t'(x1[PRV]) * prod_t'(d1[i]);
        p3[i]    <= sat_word(round_shift(wide_t'(prod2[i]), FRACTION_BITS));
        k[i]     <= sat_word(widen(p3[i]) - widen(x3[i]) + widen(f3));
      end
    end
  end

endmodule
